// ===== sv/isc_pkg.sv =====
// Package for the itemset support counter: shared widths, opcodes,
// sequencer states and the query / accumulator control structs.
// No dependencies.
package isc_pkg;

    localparam int ITEM_W    = 32;  // row and mask width on the ports
    localparam int CNT_W     = 11;  // row_count and result count width
    localparam int ROW_IDX_W = 10;  // row_index width
    localparam int TGT_W     = 5;   // target_item width

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    // Query descriptor held for the whole table walk
    typedef struct packed {
        logic [ITEM_W-1:0] pos_mask;
        logic [ITEM_W-1:0] neg_mask;
        logic [TGT_W-1:0]  target_item;
        logic              target_value;
    } t_query;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic clear;   // start of a query
        logic valid;   // a row read is on the data bus this cycle
    } t_acc_ctrl;

endpackage

// ===== sv/isc_support_acc.sv =====
// Support accumulator: tests one row per cycle against the held query and
// keeps the two saturating counts. Depends on isc_pkg.
module isc_support_acc
    import isc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_acc_ctrl         i_ctrl,
    input  t_query            i_query,
    input  logic [ITEM_W-1:0] i_row,
    output logic [CNT_W-1:0]  o_match_count,
    output logic [CNT_W-1:0]  o_target_count
);

    logic [CNT_W-1:0] r_match;
    logic [CNT_W-1:0] r_target;
    logic             row_match;
    logic             row_hit;

    // Items beyond the stored width are already zero in the row
    assign row_match = ((i_row & i_query.pos_mask) == i_query.pos_mask) &&
                       ((i_row & i_query.neg_mask) == '0);
    assign row_hit   = row_match && (i_row[i_query.target_item] == i_query.target_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_match  <= '0;
            r_target <= '0;
        end else if (i_ctrl.valid) begin
            if (row_match && (r_match != '1)) begin
                r_match <= r_match + 1'b1;
            end
            if (row_hit && (r_target != '1)) begin
                r_target <= r_target + 1'b1;
            end
        end
    end

    assign o_match_count  = r_match;
    assign o_target_count = r_target;

endmodule

// ===== sv/itemset_support_counter_unit.sv =====
// Itemset support counter top level: row table, walk sequencer and result
// register around the shared support accumulator.
// Depends on isc_pkg and isc_support_acc.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one request: either a
//    row write (opcode write) or a support query (opcode query).
//  - A row write is stored in the row table; rows at or above MAX_ROWS are
//    dropped. Writes produce no result.
//  - A query walks rows 0 .. min(row_count, MAX_ROWS)-1, one table read per
//    cycle through the single memory read port, and the accumulator tests
//    one row per cycle. When the walk ends, the done state loads both counts
//    into the output register, and the next request is taken in the same cycle
//    as the new result shows on o_out_valid. The request stall stays high for
//    the whole walk, so queries run one at a time.
//  - Output channel (o_out_valid / i_out_stall) is a holding register: a
//    finished result waits there while the receiver stalls, and new writes
//    are taken meanwhile. A second query may walk but holds its result in
//    the done state until the register is free.
//  - Configuration: i_cfg_we writes row_count; write it only while idle (unenforced).
//  - Reset (synchronous, active low) clears the sequencer, the output valid
//    and row_count. The row table is not cleared; reading a row that was
//    never written gives undefined counts.
module itemset_support_counter_unit
    import isc_pkg::*;
#(
    parameter int MAX_ROWS  = 1024,
    parameter int NUM_ITEMS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CNT_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_opcode,
    input  logic [ROW_IDX_W-1:0] i_row_index,
    input  logic [ITEM_W-1:0]    i_row_bits,
    input  logic [ITEM_W-1:0]    i_pos_mask,
    input  logic [ITEM_W-1:0]    i_neg_mask,
    input  logic [TGT_W-1:0]     i_target_item,
    input  logic                 i_target_value,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CNT_W-1:0]     o_match_count,
    output logic [CNT_W-1:0]     o_target_count
);

    // Table geometry
    localparam int AW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW      = (AW > CNT_W) ? AW : CNT_W;
    localparam int STORE_W = (NUM_ITEMS < ITEM_W) ? NUM_ITEMS : ITEM_W;
    localparam logic [ITEM_W-1:0] ITEM_MASK =
        (NUM_ITEMS >= ITEM_W) ? '1 : ITEM_W'((64'd1 << NUM_ITEMS) - 64'd1);

    logic [STORE_W-1:0] mem [MAX_ROWS];

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_row_count;
    logic [CW-1:0]      r_row;
    t_query             r_query;
    logic [STORE_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic               r_out_vld;
    logic [CNT_W-1:0]   r_out_match;
    logic [CNT_W-1:0]   r_out_target;

    logic               in_accept;
    logic               is_query;
    logic               wr_en;
    logic [CW-1:0]      limit;
    logic               more_rows;
    logic               rd_en;
    logic               load_out;
    t_acc_ctrl          acc_ctrl;
    logic [CNT_W-1:0]   acc_match;
    logic [CNT_W-1:0]   acc_target;

    assign in_accept = i_in_valid && !o_in_stall;
    assign is_query  = (i_opcode == OP_QUERY);
    assign wr_en     = in_accept && !is_query && (int'(i_row_index) < MAX_ROWS);

    // Rows in use, clamped to the table depth
    assign limit     = (int'(r_row_count) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(r_row_count);
    assign more_rows = (r_row < limit);

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= '0;
        end else if (i_cfg_we) begin
            r_row_count <= i_cfg_data;
        end
    end

    // Row table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(i_row_index)] <= i_row_bits[STORE_W-1:0];
        end
        if (rd_en) begin
            r_rd_data <= mem[r_row[AW-1:0]];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && is_query) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!more_rows) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall     = 1'b1;
        rd_en          = 1'b0;
        load_out       = 1'b0;
        acc_ctrl.clear = 1'b0;
        acc_ctrl.valid = r_rd_vld;
        case (r_state)
            S_IDLE: begin
                o_in_stall     = 1'b0;
                acc_ctrl.clear = i_in_valid && is_query;
            end
            S_WALK: begin
                rd_en = more_rows;
            end
            S_DONE: begin
                load_out = !r_out_vld || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Walk pointer and held query
    always_ff @(posedge i_clk) begin
        if (in_accept && is_query) begin
            r_row                <= '0;
            r_query.pos_mask     <= i_pos_mask & ITEM_MASK;
            r_query.neg_mask     <= i_neg_mask & ITEM_MASK;
            r_query.target_item  <= i_target_item;
            r_query.target_value <= i_target_value;
        end else if (rd_en) begin
            r_row <= r_row + 1'b1;
        end
    end

    // Result holding register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_match  <= acc_match;
            r_out_target <= acc_target;
        end
    end

    isc_support_acc u_acc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (acc_ctrl),
        .i_query        (r_query),
        .i_row          (ITEM_W'(r_rd_data)),
        .o_match_count  (acc_match),
        .o_target_count (acc_target)
    );

    assign o_out_valid    = r_out_vld;
    assign o_match_count  = r_out_match;
    assign o_target_count = r_out_target;

`ifndef SYNTHESIS
    // walk pointer never passes the clamped row count
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_row <= limit))
        else $error("walk pointer beyond row limit");

    // a taken query starts a walk from row zero
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_query) |=> ((r_state == S_WALK) && (r_row == '0)))
        else $error("query did not start walk");

    // read data only follows a walk cycle
    a_rd_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> $past(r_state == S_WALK))
        else $error("row read outside walk");

    // a new result is loaded only from the done state
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

    // target rows are a subset of matching rows
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_target_count <= o_match_count))
        else $error("target count exceeds match count");
`endif

endmodule
